// File: rtl/e2q_pkg.sv
// shared constants and helper functions for the euler to quaternion unit
package e2q_pkg;

  localparam int unsigned AngleW   = 18;
  localparam int unsigned QuatW    = 16;
  localparam int unsigned PhaseW   = 32;
  localparam int unsigned CordicN  = 30;
  localparam int unsigned StageIdxW = 5;
  localparam int unsigned TrigW    = 33;
  localparam int unsigned ProdW    = 2 * TrigW;
  localparam int unsigned SumW     = 34;

  localparam logic signed [TrigW-1:0] CordicGain = 33'sd652032874;
  localparam logic signed [TrigW-1:0] OneQ30     = 33'sd1073741824;
  localparam logic signed [TrigW-1:0] NegOneQ30  = -33'sd1073741824;
  localparam logic signed [SumW-1:0]  RoundQ15   = 34'sd16384;
  localparam logic signed [SumW-1:0]  MaxQ15     = 34'sd32767;
  localparam logic signed [SumW-1:0]  MinQ15     = -34'sd32768;

  // phase = round(a * 2^32 / 184320); 184320 = 2^12 * 45
  // so phase = round(a * 2^20 / 45)
  localparam int unsigned Div45 = 45;

  // arctangent table in phase units
  function automatic logic [PhaseW-1:0] atan_turn(input logic [StageIdxW-1:0] idx);
    logic [PhaseW-1:0] r;
    unique case (idx)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // q30 product rounded back to q30, floor((p + 2^29) >> 30)
  function automatic logic signed [TrigW-1:0] round_q30(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] t;
    t = (p + (ProdW'(1) <<< 29)) >>> 30;
    return t[TrigW-1:0];
  endfunction

  function automatic logic signed [QuatW-1:0] to_q15(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] r;
    r = (v + RoundQ15) >>> 15;
    if (r > MaxQ15) r = MaxQ15;
    else if (r < MinQ15) r = MinQ15;
    return r[QuatW-1:0];
  endfunction

endpackage

// File: rtl/e2q_sincos_lane.sv
// pipelined half angle phase and cordic sine/cosine lane
module e2q_sincos_lane (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  input  logic signed [e2q_pkg::AngleW-1:0]      angle_i,
  output logic                                   valid_o,
  output logic signed [e2q_pkg::TrigW-1:0]       sin_o,
  output logic signed [e2q_pkg::TrigW-1:0]       cos_o
);

  localparam int unsigned N      = e2q_pkg::CordicN;
  localparam int unsigned AngleW = e2q_pkg::AngleW;
  localparam int unsigned PhaseW = e2q_pkg::PhaseW;
  localparam int unsigned XW     = 36;
  // |a| = 45*k + r, so round(|a| * 2^20 / 45) = k * 2^20 + round(r * 2^20 / 45)
  // k by reciprocal multiplication, m = ceil(2^24/45) is exact for |a| <= 2^17
  localparam int unsigned KW     = 12;
  localparam int unsigned FracW  = 20;
  localparam int unsigned RecW   = 19;
  localparam int unsigned RecK   = 24;
  localparam int unsigned ProdKW = AngleW + RecW;
  localparam int unsigned RemW   = $clog2(e2q_pkg::Div45);
  localparam logic [RecW-1:0] Rec45 = 19'd372828;

  // stage 0: magnitude and k = floor(|a| / 45)
  logic              v0_q, neg0_q;
  logic [AngleW-1:0] mag_a;
  logic [ProdKW-1:0] kprod;
  logic [AngleW-1:0] mag0_q;
  logic [KW-1:0]     k0_q;

  assign mag_a = angle_i[AngleW-1] ? AngleW'(-angle_i) : AngleW'(angle_i);
  assign kprod = ProdKW'(mag_a) * ProdKW'(Rec45);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    neg0_q <= angle_i[AngleW-1];
    mag0_q <= mag_a;
    k0_q   <= kprod[RecK+KW-1:RecK];
  end

  // stage 1: remainder r and the rounded fraction of the turn from a small table
  // round half away: floor((r*2^20 + 22.5)/45) = floor((r*2^20 + 22)/45)
  logic [FracW-1:0]  frac_tab [e2q_pkg::Div45];
  logic [AngleW-1:0] kx45;
  logic [RemW-1:0]   rem;

  for (genvar j = 0; j < e2q_pkg::Div45; j++) begin : g_frac
    assign frac_tab[j] = FracW'((j * (1 << FracW) + e2q_pkg::Div45 / 2) / e2q_pkg::Div45);
  end

  assign kx45 = AngleW'(k0_q) * AngleW'(e2q_pkg::Div45);
  assign rem  = RemW'(mag0_q - kx45);

  logic                        v1_q, neg1_q;
  logic [PhaseW-1:0]           quo1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= v0_q;
  end
  always_ff @(posedge clk_i) begin
    neg1_q <= neg0_q;
    quo1_q <= {k0_q, frac_tab[rem]};
  end

  // stage 2: sign, fold
  logic [PhaseW-1:0] ph, ph_f;
  logic              flip;
  always_comb begin
    ph = neg1_q ? -quo1_q : quo1_q;
    flip = (ph[31:30] == 2'b01) || (ph[31:30] == 2'b10);
    ph_f = flip ? ph + 32'h8000_0000 : ph;
  end

  logic              vs_q [N+1];
  logic              fs_q [N+1];
  logic signed [XW-1:0] xs_q [N+1];
  logic signed [XW-1:0] ys_q [N+1];
  logic signed [XW-1:0] zs_q [N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vs_q[0] <= 1'b0;
    else vs_q[0] <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    fs_q[0] <= flip;
    xs_q[0] <= XW'(e2q_pkg::CordicGain);
    ys_q[0] <= '0;
    zs_q[0] <= XW'($signed(ph_f));
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [XW-1:0] dx, dy, at;
    assign dx = ys_q[i] >>> i;
    assign dy = xs_q[i] >>> i;
    assign at = XW'(e2q_pkg::atan_turn(e2q_pkg::StageIdxW'(i)));
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vs_q[i+1] <= 1'b0;
      else vs_q[i+1] <= vs_q[i];
    end
    always_ff @(posedge clk_i) begin
      fs_q[i+1] <= fs_q[i];
      if (!zs_q[i][XW-1]) begin
        xs_q[i+1] <= xs_q[i] - dx;
        ys_q[i+1] <= ys_q[i] + dy;
        zs_q[i+1] <= zs_q[i] - at;
      end else begin
        xs_q[i+1] <= xs_q[i] + dx;
        ys_q[i+1] <= ys_q[i] - dy;
        zs_q[i+1] <= zs_q[i] + at;
      end
    end
  end

  // output: flip and clamp
  logic signed [XW-1:0] xf, yf;
  assign xf = fs_q[N] ? -xs_q[N] : xs_q[N];
  assign yf = fs_q[N] ? -ys_q[N] : ys_q[N];

  function automatic logic signed [e2q_pkg::TrigW-1:0] clampu(input logic signed [XW-1:0] v);
    if (v > XW'(e2q_pkg::OneQ30)) return e2q_pkg::OneQ30;
    if (v < XW'(e2q_pkg::NegOneQ30)) return e2q_pkg::NegOneQ30;
    return v[e2q_pkg::TrigW-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else valid_o <= vs_q[N];
  end
  always_ff @(posedge clk_i) begin
    cos_o <= clampu(xf);
    sin_o <= clampu(yf);
  end

endmodule

// File: rtl/e2q_merge.sv
// merging stage: triple products, sums and q15 saturation
module e2q_merge (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [e2q_pkg::TrigW-1:0]  sr_i,
  input  logic signed [e2q_pkg::TrigW-1:0]  cr_i,
  input  logic signed [e2q_pkg::TrigW-1:0]  sy_i,
  input  logic signed [e2q_pkg::TrigW-1:0]  cy_i,
  input  logic signed [e2q_pkg::TrigW-1:0]  sp_i,
  input  logic signed [e2q_pkg::TrigW-1:0]  cp_i,
  output logic                              valid_o,
  output logic signed [e2q_pkg::QuatW-1:0]  quat_x_o,
  output logic signed [e2q_pkg::QuatW-1:0]  quat_y_o,
  output logic signed [e2q_pkg::QuatW-1:0]  quat_z_o,
  output logic signed [e2q_pkg::QuatW-1:0]  quat_w_o
);

  localparam int unsigned TW = e2q_pkg::TrigW;
  localparam int unsigned PW = e2q_pkg::ProdW;
  localparam int unsigned SW = e2q_pkg::SumW;

  // first products: sr*cy, cr*sy, cr*cy, sr*sy
  logic signed [TW-1:0] p_srcy_q, p_crsy_q, p_crcy_q, p_srsy_q, sp1_q, cp1_q;
  logic                 v1_q, v2_q, v3_q;
  always_ff @(posedge clk_i) begin
    p_srcy_q <= e2q_pkg::round_q30(PW'(sr_i) * PW'(cy_i));
    p_crsy_q <= e2q_pkg::round_q30(PW'(cr_i) * PW'(sy_i));
    p_crcy_q <= e2q_pkg::round_q30(PW'(cr_i) * PW'(cy_i));
    p_srsy_q <= e2q_pkg::round_q30(PW'(sr_i) * PW'(sy_i));
    sp1_q <= sp_i;
    cp1_q <= cp_i;
  end

  // second products, eight terms
  logic signed [TW-1:0] t_xa_q, t_xb_q, t_ya_q, t_yb_q, t_za_q, t_zb_q, t_wa_q, t_wb_q;
  always_ff @(posedge clk_i) begin
    t_xa_q <= e2q_pkg::round_q30(PW'(p_srcy_q) * PW'(cp1_q));
    t_xb_q <= e2q_pkg::round_q30(PW'(p_crsy_q) * PW'(sp1_q));
    t_ya_q <= e2q_pkg::round_q30(PW'(p_crsy_q) * PW'(cp1_q));
    t_yb_q <= e2q_pkg::round_q30(PW'(p_srcy_q) * PW'(sp1_q));
    t_za_q <= e2q_pkg::round_q30(PW'(p_crcy_q) * PW'(sp1_q));
    t_zb_q <= e2q_pkg::round_q30(PW'(p_srsy_q) * PW'(cp1_q));
    t_wa_q <= e2q_pkg::round_q30(PW'(p_crcy_q) * PW'(cp1_q));
    t_wb_q <= e2q_pkg::round_q30(PW'(p_srsy_q) * PW'(sp1_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    quat_x_o <= e2q_pkg::to_q15(SW'(t_xa_q) - SW'(t_xb_q));
    quat_y_o <= e2q_pkg::to_q15(SW'(t_ya_q) + SW'(t_yb_q));
    quat_z_o <= e2q_pkg::to_q15(SW'(t_za_q) - SW'(t_zb_q));
    quat_w_o <= e2q_pkg::to_q15(SW'(t_wa_q) + SW'(t_wb_q));
  end

  assign valid_o = v3_q;

endmodule

// File: rtl/euler_to_quaternion_unit.sv
// top level: euler angles to quaternion, three cordic lanes and a merging stage
//
// usage
//   command channel: roll_angle_i, yaw_angle_i, pitch_angle_i (degrees, 8 fraction
//   bits) are taken as one beat at a rising edge where start is high and busy
//   is low. busy is tied low: a new beat can enter on every cycle.
//   result channel: quat_x_o .. quat_w_o (q1.15, saturated to [-1.0, +1.0)) carry one beat
//   for exactly one cycle while done_o is high; the receiver cannot stall, so no
//   backpressure path exists and results are never held.
//   pipeline: 3 phase stages, 30 cordic stages, 1 clamp register in the lanes and
//   3 product and sum stages in the merge lie between the accepting edge and done_o.
//   throughput: one beat per cycle, set by the fully unrolled cordic pipeline.
//   reset: rst_ni clears every valid flag asynchronously; data registers are not
//   reset and no result appears until a beat has gone through.
module euler_to_quaternion_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [e2q_pkg::AngleW-1:0]  roll_angle_i,
  input  logic signed [e2q_pkg::AngleW-1:0]  yaw_angle_i,
  input  logic signed [e2q_pkg::AngleW-1:0]  pitch_angle_i,
  output logic                               done_o,
  output logic signed [e2q_pkg::QuatW-1:0]   quat_x_o,
  output logic signed [e2q_pkg::QuatW-1:0]   quat_y_o,
  output logic signed [e2q_pkg::QuatW-1:0]   quat_z_o,
  output logic signed [e2q_pkg::QuatW-1:0]   quat_w_o
);

  logic go;
  logic vr, vy, vp;
  logic signed [e2q_pkg::TrigW-1:0] sr, cr, sy, cy, sp, cp;

  // pipeline never stalls
  assign busy = 1'b0;
  assign go   = start & ~busy;

  // one lane per angle
  e2q_sincos_lane u_roll (
    .clk_i, .rst_ni, .valid_i(go), .angle_i(roll_angle_i),
    .valid_o(vr), .sin_o(sr), .cos_o(cr)
  );
  e2q_sincos_lane u_yaw (
    .clk_i, .rst_ni, .valid_i(go), .angle_i(yaw_angle_i),
    .valid_o(vy), .sin_o(sy), .cos_o(cy)
  );
  e2q_sincos_lane u_pitch (
    .clk_i, .rst_ni, .valid_i(go), .angle_i(pitch_angle_i),
    .valid_o(vp), .sin_o(sp), .cos_o(cp)
  );

  // lanes run in lockstep
  e2q_merge u_merge (
    .clk_i, .rst_ni, .valid_i(vr & vy & vp),
    .sr_i(sr), .cr_i(cr), .sy_i(sy), .cy_i(cy), .sp_i(sp), .cp_i(cp),
    .valid_o(done_o),
    .quat_x_o, .quat_y_o, .quat_z_o, .quat_w_o
  );

endmodule

// File: bench/tb.sv
// self-checking bench for the euler to quaternion unit
module tb;

  localparam int unsigned AngleW  = e2q_pkg::AngleW;
  localparam int unsigned QuatW   = e2q_pkg::QuatW;
  localparam int unsigned PhaseW  = e2q_pkg::PhaseW;
  localparam int unsigned CordicN = e2q_pkg::CordicN;

  typedef struct packed {
    logic signed [QuatW-1:0] qx;
    logic signed [QuatW-1:0] qy;
    logic signed [QuatW-1:0] qz;
    logic signed [QuatW-1:0] qw;
  } quat_t;

  // cycles without any beat moving before the run is declared hung
  localparam int StallLimit = 400;
  // pipeline depth from the accepting edge to done
  localparam int Latency    = 37;
  localparam int RandBeats  = 1500;

  localparam longint GainQ30   = 64'sd652032874;
  localparam longint UnitQ30   = 64'sd1073741824;
  localparam longint HalfTurnDeg = 64'sd184320;

  // arctangent of 2^-i, in phase units (one turn = 2^32)
  localparam longint AtanPhase [CordicN] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [AngleW-1:0] roll_angle_i = '0;
  logic signed [AngleW-1:0] yaw_angle_i = '0;
  logic signed [AngleW-1:0] pitch_angle_i = '0;
  logic done_o;
  logic signed [QuatW-1:0] quat_x_o, quat_y_o, quat_z_o, quat_w_o;

  quat_t pending_quats[$];
  int    fail_count = 0;
  int    idle_cycles = 0;

  euler_to_quaternion_unit dut (
    .clk_i, .rst_ni, .start, .busy,
    .roll_angle_i, .yaw_angle_i, .pitch_angle_i,
    .done_o, .quat_x_o, .quat_y_o, .quat_z_o, .quat_w_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // sine and cosine of half the raw angle, q2.30, via the cordic rotator
  function automatic void half_angle_trig(input longint ang, output longint sn,
                                          output longint cs);
    longint num, rq, z, px, py, dx, dy;
    logic [PhaseW-1:0] ph;
    bit flip;
    num = ang * 64'sd4294967296;
    // round half away from zero; sv division truncates like the spec
    if (num >= 0) rq = (num + HalfTurnDeg / 2) / HalfTurnDeg;
    else rq = -((-num + HalfTurnDeg / 2) / HalfTurnDeg);
    ph = rq[PhaseW-1:0];
    flip = 1'b0;
    // fold the second and third quadrant into [-90, 90) and negate later
    if (ph[31:30] == 2'd1 || ph[31:30] == 2'd2) begin
      ph = ph + 32'h8000_0000;
      flip = 1'b1;
    end
    z = longint'($signed(ph));
    px = GainQ30;
    py = 0;
    for (int i = 0; i < CordicN; i++) begin
      dx = py >>> i;
      dy = px >>> i;
      if (z >= 0) begin
        px -= dx; py += dy; z -= AtanPhase[i];
      end else begin
        px += dx; py -= dy; z += AtanPhase[i];
      end
    end
    if (flip) begin
      px = -px; py = -py;
    end
    cs = (px > UnitQ30) ? UnitQ30 : (px < -UnitQ30) ? -UnitQ30 : px;
    sn = (py > UnitQ30) ? UnitQ30 : (py < -UnitQ30) ? -UnitQ30 : py;
  endfunction

  function automatic longint rmul(longint a, longint b);
    return (a * b + UnitQ30 / 2) >>> 30;
  endfunction

  function automatic logic signed [QuatW-1:0] sat_q15(longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[QuatW-1:0];
  endfunction

  function automatic quat_t euler_to_quat(longint roll, longint yaw, longint pitch);
    longint sr, cr, sy, cy, sp, cp;
    quat_t q;
    half_angle_trig(roll, sr, cr);
    half_angle_trig(yaw, sy, cy);
    half_angle_trig(pitch, sp, cp);
    // each triple product rounds after every multiply, left to right
    q.qx = sat_q15(rmul(rmul(sr, cy), cp) - rmul(rmul(cr, sy), sp));
    q.qy = sat_q15(rmul(rmul(cr, sy), cp) + rmul(rmul(sr, cy), sp));
    q.qz = sat_q15(rmul(rmul(cr, cy), sp) - rmul(rmul(sr, sy), cp));
    q.qw = sat_q15(rmul(rmul(cr, cy), cp) + rmul(rmul(sr, sy), sp));
    return q;
  endfunction

  // command side monitor: predict on every accepted beat
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy)
      pending_quats.insert(pending_quats.size(),
                           euler_to_quat(roll_angle_i, yaw_angle_i, pitch_angle_i));
  end

  // result side: compare each done beat against the oldest prediction
  always @(posedge clk_i) begin
    quat_t want;
    if (rst_ni && done_o) begin
      if (pending_quats.size() == 0) begin
        $display("%0t: unexpected result beat x=%0d y=%0d z=%0d w=%0d",
                 $time, quat_x_o, quat_y_o, quat_z_o, quat_w_o);
        fail_count++;
      end else begin
        want = pending_quats.pop_front();
        if (want.qx !== quat_x_o || want.qy !== quat_y_o ||
            want.qz !== quat_z_o || want.qw !== quat_w_o) begin
          $display("%0t: mismatch expected x=%0d y=%0d z=%0d w=%0d got x=%0d y=%0d z=%0d w=%0d",
                   $time, want.qx, want.qy, want.qz, want.qw,
                   quat_x_o, quat_y_o, quat_z_o, quat_w_o);
          fail_count++;
        end
      end
    end
  end

  // watchdog: any beat on either side resets the count
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one, often none
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // one beat on the command side; start stays high if the next beat follows at once
  task automatic send_attitude(input logic signed [AngleW-1:0] r,
                               input logic signed [AngleW-1:0] y,
                               input logic signed [AngleW-1:0] p, input int gap);
    bit ready;
    start <= 1'b1;
    roll_angle_i <= r;
    yaw_angle_i <= y;
    pitch_angle_i <= p;
    do begin
      @(negedge clk_i);
      ready = !busy;
      @(posedge clk_i);
    end while (!ready);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    while (pending_quats.size() != 0) @(posedge clk_i);
  endtask

  // zero attitude gives w at +1.0 (saturates), then field extremes and quarter turns
  task automatic test_directed();
    logic signed [AngleW-1:0] corners [10] = '{
      18'sd0, 18'sd92160, -18'sd92160, 18'sd23040, -18'sd23040,
      18'sd46080, -18'sd46080, 18'sd131071, 18'sh20000, 18'sd1
    };
    send_attitude('0, '0, '0, 0);
    foreach (corners[i]) send_attitude(corners[i], '0, '0, 0);
    foreach (corners[i]) send_attitude('0, corners[i], '0, 0);
    send_attitude('0, '0, 18'sd92160, 0);
    send_attitude('0, '0, 18'sh20000, 0);
    send_attitude(18'sd131071, 18'sh20000, 18'sd46080, 0);
    send_attitude(-18'sd23040, 18'sd23040, -18'sd92160, 2);
  endtask

  // pause until the pipeline has emptied
  task automatic test_drain_pause();
    start <= 1'b0;
    drain_results();
    send_attitude(18'sd11520, -18'sd34560, 18'sd5760, 0);
  endtask

  // random angles: most within +-360 degrees, some over the whole field
  task automatic test_random();
    logic signed [AngleW-1:0] a [3];
    for (int n = 0; n < RandBeats; n++) begin
      foreach (a[k]) begin
        if ($urandom_range(0, 3) == 0) a[k] = AngleW'($urandom());
        else a[k] = AngleW'($signed($urandom_range(0, 184320)) - 92160);
      end
      send_attitude(a[0], a[1], a[2], (n % 200 < 40) ? 0 : pick_gap());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_drain_pause();
    test_random();
    start <= 1'b0;
    drain_results();
    repeat (Latency + 10) @(posedge clk_i);
    if (fail_count == 0 && pending_quats.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// File: euler_to_quaternion_unit.f
rtl/e2q_pkg.sv
rtl/e2q_sincos_lane.sv
rtl/e2q_merge.sv
rtl/euler_to_quaternion_unit.sv
bench/tb.sv
